>>> rtl/core/encoder_velocity_pid_loop_top_macros.svh
// Assertion macros used by the velocity PID loop sequencer.
`ifndef ENCODER_VELOCITY_PID_LOOP_TOP_MACROS_SVH
`define ENCODER_VELOCITY_PID_LOOP_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define EVPID_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define EVPID_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/evpid_pkg.sv
// Types, widths, constants and helpers of the velocity PID loop.
`default_nettype none
package evpid_pkg;

  localparam int CNT_W      = 16;
  localparam int CMD_W      = 8;
  localparam int VEL_W      = 32;
  localparam int GAIN_W     = 24;
  localparam int FW_W       = 17;
  localparam int UL_W       = 7;
  localparam int LL_W       = 8;
  localparam int DRV_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Shared multiplier: signed A times unsigned B
  localparam int OPA_W  = 33;
  localparam int OPB_W  = 25;
  localparam int PROD_W = OPA_W + OPB_W + 1;
  // Working width for sums before saturation or clamping
  localparam int WIDE_W = PROD_W + 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN    = 3'd0,
    CFG_INTEG_GAIN   = 3'd1,
    CFG_DERIV_GAIN   = 3'd2,
    CFG_TICKS_TO_VEL = 3'd3,
    CFG_FILTER_WT    = 3'd4,
    CFG_CMD_TO_VEL   = 3'd5,
    CFG_UPPER_LIM    = 3'd6,
    CFG_LOWER_LIM    = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integ_gain_dt;
    logic [GAIN_W-1:0] deriv_gain_over_dt;
    logic [GAIN_W-1:0] ticks_to_velocity;
    logic [FW_W-1:0]   filter_weight;
    logic [GAIN_W-1:0] command_to_velocity;
    logic [UL_W-1:0]   drive_upper_limit;
    logic [LL_W-1:0]   drive_lower_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    prop_gain:           24'd65536,
    integ_gain_dt:       24'd328,
    deriv_gain_over_dt:  24'd0,
    ticks_to_velocity:   24'd65536,
    filter_weight:       17'd16384,
    command_to_velocity: 24'd655,
    drive_upper_limit:   7'd100,
    drive_lower_limit:   8'h9C
  };

  typedef struct packed {
    logic             issue;
    logic [OPA_W-1:0] a;
    logic [OPB_W-1:0] b;
  } mul_req_t;

  localparam logic signed [WIDE_W-1:0] WIDE_VMAX =
    {{(WIDE_W-VEL_W+1){1'b0}}, {(VEL_W-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] WIDE_VMIN =
    {{(WIDE_W-VEL_W+1){1'b1}}, {(VEL_W-1){1'b0}}};

  function automatic logic signed [WIDE_W-1:0] ext_vel(input logic signed [VEL_W-1:0] v);
    return {{(WIDE_W-VEL_W){v[VEL_W-1]}}, v};
  endfunction

  function automatic logic signed [WIDE_W-1:0] ext_prod(input logic signed [PROD_W-1:0] v);
    return {{(WIDE_W-PROD_W){v[PROD_W-1]}}, v};
  endfunction

  // Saturate to the signed 32-bit range
  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [WIDE_W-1:0] v);
    logic signed [VEL_W-1:0] r;
    if (v > WIDE_VMAX) begin
      r = {1'b0, {(VEL_W-1){1'b1}}};
    end else if (v < WIDE_VMIN) begin
      r = {1'b1, {(VEL_W-1){1'b0}}};
    end else begin
      r = v[VEL_W-1:0];
    end
    return r;
  endfunction

  // Upper bound first, then lower bound, so the lower one wins when they cross
  function automatic logic signed [VEL_W-1:0] clamp_lim(input logic signed [WIDE_W-1:0] v,
                                                        input logic signed [VEL_W-1:0] lo,
                                                        input logic signed [VEL_W-1:0] hi);
    logic signed [WIDE_W-1:0] t;
    logic signed [VEL_W-1:0]  r;
    t = (v > ext_vel(hi)) ? ext_vel(hi) : v;
    r = (t < ext_vel(lo)) ? lo : t[VEL_W-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/evpid_in_if.sv
// Input channel: encoder count and speed command per control tick.
`default_nettype none
interface evpid_in_if;
  logic              valid;
  logic              ready;
  logic [15:0]       encoder_count;
  logic signed [7:0] speed_command;

  modport source (output valid, output encoder_count, output speed_command, input ready);
  modport sink   (input valid, input encoder_count, input speed_command, output ready);
endinterface
`default_nettype wire

>>> rtl/core/evpid_out_if.sv
// Result channel: motor drive and filtered velocity.
`default_nettype none
interface evpid_out_if;
  logic               valid;
  logic               ready;
  logic signed [7:0]  motor_drive;
  logic signed [31:0] filtered_velocity;

  modport source (output valid, output motor_drive, output filtered_velocity, input ready);
  modport sink   (input valid, input motor_drive, input filtered_velocity, output ready);
endinterface
`default_nettype wire

>>> rtl/core/evpid_cfg_regs.sv
// Configuration register file of the velocity PID loop.
`default_nettype none
module evpid_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [evpid_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [evpid_pkg::CFG_DATA_W-1:0] cfg_data,
  output evpid_pkg::cfg_t                  cfg
);
  import evpid_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  // Register write decode; each field keeps its low bits
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_e'(cfg_index))
        CFG_PROP_GAIN:    cfg_nxt.prop_gain           = cfg_data[GAIN_W-1:0];
        CFG_INTEG_GAIN:   cfg_nxt.integ_gain_dt       = cfg_data[GAIN_W-1:0];
        CFG_DERIV_GAIN:   cfg_nxt.deriv_gain_over_dt  = cfg_data[GAIN_W-1:0];
        CFG_TICKS_TO_VEL: cfg_nxt.ticks_to_velocity   = cfg_data[GAIN_W-1:0];
        CFG_FILTER_WT:    cfg_nxt.filter_weight       = cfg_data[FW_W-1:0];
        CFG_CMD_TO_VEL:   cfg_nxt.command_to_velocity = cfg_data[GAIN_W-1:0];
        CFG_UPPER_LIM:    cfg_nxt.drive_upper_limit   = cfg_data[UL_W-1:0];
        CFG_LOWER_LIM:    cfg_nxt.drive_lower_limit   = cfg_data[LL_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

>>> rtl/core/evpid_mul.sv
// Shared signed-by-unsigned multiplier with registered product.
`default_nettype none
module evpid_mul (
  input  logic                                  clk,
  input  evpid_pkg::mul_req_t                   req,
  output logic signed [evpid_pkg::PROD_W-1:0]   prod_r
);
  import evpid_pkg::*;

  logic signed [OPA_W-1:0] op_a;
  logic signed [OPB_W:0]   op_b;

  assign op_a = req.a;
  assign op_b = {1'b0, req.b};

  // Product lands in the cycle after issue and holds until the next issue
  always_ff @(posedge clk) begin
    if (req.issue) begin
      prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/evpid_seq.sv
// Sequencer and datapath registers of the velocity PID loop.
`default_nettype none
`include "encoder_velocity_pid_loop_top_macros.svh"
module evpid_seq #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  evpid_in_if.sink                            in_ch,
  evpid_out_if.source                         out_ch,
  input  evpid_pkg::cfg_t                     cfg,
  output evpid_pkg::mul_req_t                 mreq,
  input  logic signed [evpid_pkg::PROD_W-1:0] prod_r
);
  import evpid_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_RAW    = 11'b000_0000_0010,
    S_LEAK   = 11'b000_0000_0100,
    S_NEW    = 11'b000_0000_1000,
    S_SMOOTH = 11'b000_0001_0000,
    S_ERR    = 11'b000_0010_0000,
    S_PROP   = 11'b000_0100_0000,
    S_INTEG  = 11'b000_1000_0000,
    S_DERIV  = 11'b001_0000_0000,
    S_SUM    = 11'b010_0000_0000,
    S_FIN    = 11'b100_0000_0000
  } state_t;

  localparam logic [OPB_W-1:0]        ONE_W    = OPB_W'(1) << FRAC_BITS;
  localparam logic signed [VEL_W:0]   RND_BIAS = ((VEL_W+1)'(1) << FRAC_BITS) - (VEL_W+1)'(1);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Loop state
  logic [CNT_W-1:0]        prev_count_r;
  logic signed [VEL_W-1:0] smoothed_r;
  logic signed [VEL_W-1:0] integral_r;
  logic signed [VEL_W-1:0] last_error_r;

  // Per-item working registers
  logic signed [CMD_W-1:0]  cmd_r;
  logic signed [CNT_W-1:0]  delta_r;
  logic [OPB_W-1:0]         w_eff_r;
  logic [OPB_W-1:0]         w_comp_r;
  logic signed [VEL_W-1:0]  raw_r;
  logic signed [PROD_W-1:0] acc_r;
  logic signed [VEL_W-1:0]  error_r;
  logic signed [VEL_W:0]    ediff_r;
  logic signed [PROD_W-1:0] p_r;
  logic signed [VEL_W-1:0]  sum_r;
  logic signed [DRV_W-1:0]  out_drive_r;
  logic signed [VEL_W-1:0]  out_vel_r;

  logic                     accept;
  logic                     fin_fire;
  logic [OPB_W-1:0]         fw_ext;
  logic [OPB_W-1:0]         w_eff;
  logic signed [VEL_W-1:0]  lo_lim;
  logic signed [VEL_W-1:0]  hi_lim;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [PROD_W:0]   smooth_sum;
  logic signed [PROD_W:0]   smooth_sh;
  logic signed [VEL_W-1:0]  raw_nxt;
  logic signed [VEL_W-1:0]  smooth_nxt;
  logic signed [VEL_W-1:0]  err_nxt;
  logic signed [VEL_W:0]    ediff_nxt;
  logic signed [VEL_W-1:0]  integ_nxt;
  logic signed [VEL_W-1:0]  sum_nxt;
  logic signed [VEL_W:0]    sum_ext;
  logic signed [VEL_W:0]    drive_full;
  logic signed [VEL_W-1:0]  lo_base;
  logic signed [VEL_W-1:0]  hi_base;

  assign accept   = in_ch.valid && in_ch.ready;
  assign fin_fire = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  // Filter weight saturates at one
  assign fw_ext = {{(OPB_W-FW_W){1'b0}}, cfg.filter_weight};
  assign w_eff  = (fw_ext > ONE_W) ? ONE_W : fw_ext;

  // Drive limits scaled to fixed point
  assign lo_base = {{(VEL_W-LL_W){cfg.drive_lower_limit[LL_W-1]}}, cfg.drive_lower_limit};
  assign hi_base = {{(VEL_W-UL_W){1'b0}}, cfg.drive_upper_limit};
  assign lo_lim  = lo_base <<< FRAC_BITS;
  assign hi_lim  = hi_base <<< FRAC_BITS;

  // Post-multiply arithmetic; the shifts floor toward minus infinity
  always_comb begin
    prod_sh    = prod_r >>> FRAC_BITS;
    raw_nxt    = sat_vel(ext_prod(prod_r));
    smooth_sum = {acc_r[PROD_W-1], acc_r} + {prod_r[PROD_W-1], prod_r};
    smooth_sh  = smooth_sum >>> FRAC_BITS;
    smooth_nxt = sat_vel({smooth_sh[PROD_W], smooth_sh});
    err_nxt    = sat_vel(ext_prod(prod_r) - ext_vel(smoothed_r));
    ediff_nxt  = {error_r[VEL_W-1], error_r} - {last_error_r[VEL_W-1], last_error_r};
    integ_nxt  = clamp_lim(ext_vel(integral_r) + ext_prod(prod_sh), lo_lim, hi_lim);
    sum_nxt    = clamp_lim(ext_prod(p_r) + ext_vel(integral_r) + ext_prod(prod_sh),
                           lo_lim, hi_lim);
    // Truncate toward zero: bias negative values before the shift
    sum_ext    = {sum_r[VEL_W-1], sum_r};
    if (sum_r[VEL_W-1]) begin
      drive_full = (sum_ext + RND_BIAS) >>> FRAC_BITS;
    end else begin
      drive_full = sum_ext >>> FRAC_BITS;
    end
  end

  // Multiplier operand select per step
  always_comb begin
    mreq.issue = 1'b0;
    mreq.a     = '0;
    mreq.b     = '0;
    unique case (state_r)
      S_RAW: begin
        mreq.issue = 1'b1;
        mreq.a     = {{(OPA_W-CNT_W){delta_r[CNT_W-1]}}, delta_r};
        mreq.b     = {1'b0, cfg.ticks_to_velocity};
      end
      S_LEAK: begin
        mreq.issue = 1'b1;
        mreq.a     = {smoothed_r[VEL_W-1], smoothed_r};
        mreq.b     = w_comp_r;
      end
      S_NEW: begin
        mreq.issue = 1'b1;
        mreq.a     = {raw_r[VEL_W-1], raw_r};
        mreq.b     = w_eff_r;
      end
      S_SMOOTH: begin
        mreq.issue = 1'b1;
        mreq.a     = {{(OPA_W-CMD_W){cmd_r[CMD_W-1]}}, cmd_r};
        mreq.b     = {1'b0, cfg.command_to_velocity};
      end
      S_PROP: begin
        mreq.issue = 1'b1;
        mreq.a     = {error_r[VEL_W-1], error_r};
        mreq.b     = {1'b0, cfg.prop_gain};
      end
      S_INTEG: begin
        mreq.issue = 1'b1;
        mreq.a     = {error_r[VEL_W-1], error_r};
        mreq.b     = {1'b0, cfg.integ_gain_dt};
      end
      S_DERIV: begin
        mreq.issue = 1'b1;
        mreq.a     = ediff_r;
        mreq.b     = {1'b0, cfg.deriv_gain_over_dt};
      end
      default: ;
    endcase
  end

  // Step sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (accept) state_nxt = S_RAW;
      S_RAW:    state_nxt = S_LEAK;
      S_LEAK:   state_nxt = S_NEW;
      S_NEW:    state_nxt = S_SMOOTH;
      S_SMOOTH: state_nxt = S_ERR;
      S_ERR:    state_nxt = S_PROP;
      S_PROP:   state_nxt = S_INTEG;
      S_INTEG:  state_nxt = S_DERIV;
      S_DERIV:  state_nxt = S_SUM;
      S_SUM:    state_nxt = S_FIN;
      S_FIN:    if (fin_fire) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fin_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control and loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      prev_count_r <= '0;
      smoothed_r   <= '0;
      integral_r   <= '0;
      last_error_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        prev_count_r <= in_ch.encoder_count;
      end
      if (state_r == S_SMOOTH) begin
        smoothed_r <= smooth_nxt;
      end
      if (state_r == S_DERIV) begin
        integral_r <= integ_nxt;
      end
      // Zero command stops the loop and clears the integral and the last error
      if (fin_fire) begin
        if (cmd_r == '0) begin
          integral_r   <= '0;
          last_error_r <= '0;
        end else begin
          last_error_r <= error_r;
        end
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= in_ch.speed_command;
      delta_r  <= in_ch.encoder_count - prev_count_r;
      w_eff_r  <= w_eff;
      w_comp_r <= ONE_W - w_eff;
    end
    if (state_r == S_LEAK)  raw_r   <= raw_nxt;
    if (state_r == S_NEW)   acc_r   <= prod_r;
    if (state_r == S_ERR)   error_r <= err_nxt;
    if (state_r == S_PROP)  ediff_r <= ediff_nxt;
    if (state_r == S_INTEG) p_r     <= prod_sh;
    if (state_r == S_SUM)   sum_r   <= sum_nxt;
    if (fin_fire) begin
      out_drive_r <= (cmd_r == '0) ? '0 : drive_full[DRV_W-1:0];
      out_vel_r   <= smoothed_r;
    end
  end

  assign in_ch.ready              = (state_r == S_IDLE);
  assign out_ch.valid             = out_valid_r;
  assign out_ch.motor_drive       = out_drive_r;
  assign out_ch.filtered_velocity = out_vel_r;

  `EVPID_ASSERT_NXT(a_busy_after_accept, clk, rst_n, accept, !in_ch.ready, "input taken while an item is in flight")
  `EVPID_ASSERT_NXT(a_zero_cmd_clears, clk, rst_n, fin_fire && (cmd_r == '0), (out_drive_r == '0) && (integral_r == '0) && (last_error_r == '0), "zero command did not stop the loop")
  `EVPID_ASSERT_IMP(a_out_from_fin, clk, rst_n, $rose(out_valid_r), $past(state_r == S_FIN), "result raised outside the final step")

endmodule
`default_nettype wire

>>> rtl/core/encoder_velocity_pid_loop_top.sv
// Encoder velocity PID loop: top level with config registers, sequencer and multiplier.
//
// One item per control tick: the encoder count delta becomes a velocity, is
// low-pass filtered, and a PID step with clamped integral produces the motor
// drive. All products go through one 33x25 signed-by-unsigned multiplier,
// issued seven times per item under a fixed step sequence. A new item is
// taken only after the last one has run its steps and its result has been
// loaded into the output register. in_ch.ready is high only while the
// sequencer waits for an item; a waiting result does not block acceptance,
// but the final step holds until the output register is free.
// Configuration writes take effect on the next clock and belong between items.
`default_nettype none
module encoder_velocity_pid_loop_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  evpid_in_if.sink                         in_ch,
  evpid_out_if.source                      out_ch,
  input  logic                             cfg_we,
  input  logic [evpid_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [evpid_pkg::CFG_DATA_W-1:0] cfg_data
);
  import evpid_pkg::*;

  cfg_t                     cfg;
  mul_req_t                 mreq;
  logic signed [PROD_W-1:0] prod_r;

  evpid_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  evpid_mul u_mul (
    .clk    (clk),
    .req    (mreq),
    .prod_r (prod_r)
  );

  evpid_seq #(
    .FRAC_BITS (FRAC_BITS)
  ) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg),
    .mreq   (mreq),
    .prod_r (prod_r)
  );

endmodule
`default_nettype wire

>>> bench/tb_encoder_velocity_pid_loop_top.sv
// Self-checking testbench for the encoder velocity PID loop top level.
`timescale 1ns / 1ps
module tb_encoder_velocity_pid_loop_top;
  import evpid_pkg::*;

  localparam int FRAC        = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE      = 16;
  localparam int HOLD_AT     = 600;
  localparam int HOLD_LEN    = 240;

  typedef struct packed {
    logic [15:0]       encoder_count;
    logic signed [7:0] speed_command;
  } tick_t;

  typedef struct packed {
    logic signed [7:0]  motor_drive;
    logic signed [31:0] filtered_velocity;
  } drive_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  evpid_in_if  in_ch ();
  evpid_out_if out_ch ();

  encoder_velocity_pid_loop_top #(.FRAC_BITS(FRAC)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Stimulus and expected drive values
  tick_t  tick_q[$];
  drive_t drive_expect_q[$];
  tick_t  next_tick;
  drive_t exp_drive;

  // Loop model: its own copy of the registers and state
  cfg_t              loop_cfg;
  logic [15:0]       mdl_prev_count;
  int                mdl_smooth_vel;
  int                mdl_integ;
  int                mdl_last_err;

  // Idling control
  bit          idle_on;
  int          src_idle_pct;
  int          sink_idle_pct;
  int          src_gap;
  int          sink_gap;
  int          hold_cnt;
  bit          hold_done;
  int          results_seen;
  int          error_count;
  int          stall_cycles;
  logic [15:0]       enc_pos;
  logic signed [7:0] cur_cmd;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint sat_to_32(longint v);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  // Upper bound first, lower bound last: crossed limits resolve to the lower one
  function automatic longint clamp_drive(longint v, longint lo, longint hi);
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v;
  endfunction

  // One control tick of the loop; updates the model state
  function automatic drive_t run_control_tick(tick_t t);
    longint      one, lo, hi, delta, raw, w, target, err, p, d, sum;
    logic [15:0] diff;
    drive_t      r;
    one = longint'(1) << FRAC;
    hi  = longint'(loop_cfg.drive_upper_limit) * one;
    lo  = longint'($signed(loop_cfg.drive_lower_limit)) * one;

    // count delta with 16-bit wrap, scaled to a velocity
    diff  = t.encoder_count - mdl_prev_count;
    delta = longint'($signed(diff));
    mdl_prev_count = t.encoder_count;
    raw = sat_to_32(delta * longint'(loop_cfg.ticks_to_velocity));

    // low-pass filter, weight capped at 1.0
    w = longint'(loop_cfg.filter_weight);
    if (w > one) w = one;
    mdl_smooth_vel = int'(sat_to_32((w * raw + (one - w) * longint'(mdl_smooth_vel)) >>> FRAC));

    // PID step
    target = longint'($signed(t.speed_command)) * longint'(loop_cfg.command_to_velocity);
    err    = sat_to_32(target - longint'(mdl_smooth_vel));
    p      = (longint'(loop_cfg.prop_gain) * err) >>> FRAC;
    mdl_integ = int'(clamp_drive(longint'(mdl_integ) +
                     ((longint'(loop_cfg.integ_gain_dt) * err) >>> FRAC), lo, hi));
    d = (longint'(loop_cfg.deriv_gain_over_dt) * (err - longint'(mdl_last_err))) >>> FRAC;
    mdl_last_err = int'(err);
    sum = clamp_drive(p + longint'(mdl_integ) + d, lo, hi);

    r.motor_drive       = 8'(sum / one);
    r.filtered_velocity = mdl_smooth_vel;
    // stop command: no drive, integrator and error history cleared
    if (t.speed_command == 0) begin
      r.motor_drive = '0;
      mdl_integ     = 0;
      mdl_last_err  = 0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    error_count++;
    if (error_count <= 10)
      $display("[%0t] mismatch on result %0d: %s", $time, results_seen, msg);
  endtask

  // Input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      src_gap = 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (src_gap != 0) begin
        src_gap--;
        in_ch.valid <= 1'b0;
      end else if (tick_q.size() != 0) begin
        next_tick = tick_q.pop_front();
        in_ch.valid         <= 1'b1;
        in_ch.encoder_count <= next_tick.encoder_count;
        in_ch.speed_command <= next_tick.speed_command;
        if (idle_on && $urandom_range(0, 99) < src_idle_pct)
          src_gap = $urandom_range(1, 13);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: register mirror, prediction, result check, result ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      loop_cfg       = CFG_RESET;
      mdl_prev_count = '0;
      mdl_smooth_vel = 0;
      mdl_integ      = 0;
      mdl_last_err   = 0;
      drive_expect_q.delete();
      sink_gap  = 0;
      hold_cnt  = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PROP_GAIN:    loop_cfg.prop_gain           = cfg_data;
          CFG_INTEG_GAIN:   loop_cfg.integ_gain_dt       = cfg_data;
          CFG_DERIV_GAIN:   loop_cfg.deriv_gain_over_dt  = cfg_data;
          CFG_TICKS_TO_VEL: loop_cfg.ticks_to_velocity   = cfg_data;
          CFG_FILTER_WT:    loop_cfg.filter_weight       = cfg_data[FW_W-1:0];
          CFG_CMD_TO_VEL:   loop_cfg.command_to_velocity = cfg_data;
          CFG_UPPER_LIM:    loop_cfg.drive_upper_limit   = cfg_data[UL_W-1:0];
          CFG_LOWER_LIM:    loop_cfg.drive_lower_limit   = cfg_data[LL_W-1:0];
          default: ;
        endcase
      end

      // result check against the oldest expectation
      if (out_ch.valid && out_ch.ready) begin
        if (drive_expect_q.size() == 0) begin
          report_mismatch($sformatf("unexpected item: drive %0d, velocity %0d",
                                    out_ch.motor_drive, out_ch.filtered_velocity));
        end else begin
          exp_drive = drive_expect_q.pop_front();
          if (out_ch.motor_drive !== exp_drive.motor_drive)
            report_mismatch($sformatf("motor_drive expected %0d, got %0d",
                                      exp_drive.motor_drive, out_ch.motor_drive));
          if (out_ch.filtered_velocity !== exp_drive.filtered_velocity)
            report_mismatch($sformatf("filtered_velocity expected %0d, got %0d",
                                      exp_drive.filtered_velocity,
                                      out_ch.filtered_velocity));
        end
        results_seen++;
      end

      if (in_ch.valid && in_ch.ready) begin
        next_tick.encoder_count = in_ch.encoder_count;
        next_tick.speed_command = in_ch.speed_command;
        drive_expect_q.push_back(run_control_tick(next_tick));
      end

      // one long hold-off so the block backs up and stalls its input
      if (!hold_done && results_seen == HOLD_AT) begin
        hold_cnt  = HOLD_LEN;
        hold_done = 1'b1;
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        out_ch.ready <= 1'b0;
      end else if (sink_gap != 0) begin
        sink_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (idle_on && $urandom_range(0, 99) < sink_idle_pct)
          sink_gap = $urandom_range(1, 13);
      end
    end
  end

  // Watchdog: cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic queue_tick(logic [15:0] cnt, logic signed [7:0] cmd);
    tick_t t;
    t.encoder_count = cnt;
    t.speed_command = cmd;
    tick_q.push_back(t);
  endtask

  task automatic wait_for_idle();
    do @(negedge clk);
    while (tick_q.size() != 0 || in_ch.valid || drive_expect_q.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  // All registers; unused upper data bits carry noise
  task automatic load_config(cfg_t c);
    write_reg(CFG_PROP_GAIN, c.prop_gain);
    write_reg(CFG_INTEG_GAIN, c.integ_gain_dt);
    write_reg(CFG_DERIV_GAIN, c.deriv_gain_over_dt);
    write_reg(CFG_TICKS_TO_VEL, c.ticks_to_velocity);
    write_reg(CFG_FILTER_WT, {7'($urandom), c.filter_weight});
    write_reg(CFG_CMD_TO_VEL, c.command_to_velocity);
    write_reg(CFG_UPPER_LIM, {17'($urandom), c.drive_upper_limit});
    write_reg(CFG_LOWER_LIM, {16'($urandom), c.drive_lower_limit});
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Gains: zero, all ones, up to 0x40000 (4.0), or full-range random values
  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return GAIN_W'($urandom_range(0, 32'h40000));
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 10;
      2:       return 30;
      default: return 60;
    endcase
  endfunction

  task automatic load_random_config();
    cfg_t c;
    c.prop_gain           = pick_gain();
    c.integ_gain_dt       = pick_gain();
    c.deriv_gain_over_dt  = pick_gain();
    c.ticks_to_velocity   = pick_gain();
    c.command_to_velocity = pick_gain();
    case ($urandom_range(0, 3))
      0:       c.filter_weight = '0;
      1:       c.filter_weight = 17'd65536;
      2:       c.filter_weight = 17'($urandom_range(65537, 131071));
      default: c.filter_weight = 17'($urandom_range(0, 65536));
    endcase
    case ($urandom_range(0, 3))
      0:       c.drive_upper_limit = '0;
      1:       c.drive_upper_limit = 7'd127;
      default: c.drive_upper_limit = 7'($urandom_range(1, 126));
    endcase
    // lower limit: mostly negative, sometimes zero or above the upper one
    case ($urandom_range(0, 4))
      0:       c.drive_lower_limit = 8'h80;
      1:       c.drive_lower_limit = '0;
      2:       c.drive_lower_limit = 8'($urandom_range(1, 127));
      default: c.drive_lower_limit = 8'(256 - $urandom_range(1, 127));
    endcase
    load_config(c);
  endtask

  // Mostly a moving encoder with held commands; some jumps and command flips
  task automatic queue_random_ticks(int n);
    int span;
    case ($urandom_range(0, 3))
      0:       span = 3;
      1:       span = 60;
      2:       span = 1500;
      default: span = 32767;
    endcase
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 85)
        enc_pos = 16'(enc_pos + $urandom_range(0, 2 * span) - span);
      else
        enc_pos = 16'($urandom);
      if ($urandom_range(0, 99) < 15) begin
        if ($urandom_range(0, 3) == 0) cur_cmd = '0;
        else cur_cmd = 8'($urandom);
      end
      queue_tick(enc_pos, cur_cmd);
    end
  endtask

  initial begin
    cfg_t c;
    in_ch.valid         = 1'b0;
    in_ch.encoder_count = '0;
    in_ch.speed_command = '0;
    out_ch.ready        = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    rst_n               = 1'b0;
    idle_on             = 1'b1;
    src_idle_pct        = 20;
    sink_idle_pct       = 20;
    hold_done           = 1'b0;
    results_seen        = 0;
    error_count         = 0;
    stall_cycles        = 0;
    enc_pos             = '0;
    cur_cmd             = 8'sd40;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset values: count wrap both ways, command extremes, stop in mid-run
    queue_tick(16'h0000, 8'sd0);
    queue_tick(16'h7FFF, 8'sd127);
    queue_tick(16'hFFFF, -8'sd128);
    queue_tick(16'h0000, 8'sd1);
    queue_tick(16'hFFFF, -8'sd1);
    queue_tick(16'h0010, 8'sd0);
    queue_tick(16'h0020, 8'sd100);
    queue_tick(16'h0030, 8'sd100);
    queue_tick(16'h0040, 8'sd100);
    queue_tick(16'h8040, 8'sd127);
    wait_for_idle();

    // everything at maximum, weight above one: raw and error saturate
    c = '{prop_gain: '1, integ_gain_dt: '1, deriv_gain_over_dt: '1,
          ticks_to_velocity: '1, filter_weight: '1, command_to_velocity: '1,
          drive_upper_limit: 7'd127, drive_lower_limit: 8'h80};
    load_config(c);
    queue_tick(16'h0040, 8'sd127);
    queue_tick(16'h803F, -8'sd128);
    queue_tick(16'h803F, 8'sd127);
    queue_tick(16'h003F, 8'sd0);
    queue_tick(16'h1234, -8'sd1);
    queue_tick(16'hFFFF, 8'sd127);
    queue_tick(16'h0000, -8'sd128);
    wait_for_idle();

    // crossed limits: lower limit above the upper one wins
    c = CFG_RESET;
    c.prop_gain         = 24'h010000;
    c.filter_weight     = 17'h08000;
    c.drive_upper_limit = 7'd0;
    c.drive_lower_limit = 8'd127;
    load_config(c);
    queue_tick(16'h0100, 8'sd50);
    queue_tick(16'h0000, -8'sd50);
    queue_tick(16'h0000, 8'sd0);
    queue_tick(16'hF000, -8'sd128);
    wait_for_idle();

    // all registers at zero
    c = '0;
    load_config(c);
    queue_tick(16'h5555, 8'sd85);
    queue_tick(16'hAAAA, -8'sd86);
    queue_tick(16'h0001, 8'sd0);
    queue_tick(16'hFFFE, 8'sd127);
    wait_for_idle();

    // random phases; the last one runs without idling
    for (int ph = 0; ph < 14; ph++) begin
      if (ph == 13) begin
        idle_on = 1'b0;
      end else begin
        src_idle_pct  = pick_pct();
        sink_idle_pct = pick_pct();
      end
      load_random_config();
      queue_random_ticks(125);
      wait_for_idle();
    end

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/evpid_pkg.sv
rtl/core/evpid_in_if.sv
rtl/core/evpid_out_if.sv
rtl/core/evpid_cfg_regs.sv
rtl/core/evpid_mul.sv
rtl/core/evpid_seq.sv
rtl/core/encoder_velocity_pid_loop_top.sv
bench/tb_encoder_velocity_pid_loop_top.sv
